// ----- design/assert_macros.svh -----
// Assertion macros included by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/hsvled_pkg.sv -----
// Constants and helper functions of the HSV/RGB LED symbol encoder.
package hsvled_pkg;

    localparam int MAX_PIXELS    = 1024;
    localparam int S_DATA_W      = 72;
    localparam int M_DATA_W      = 88;
    localparam int CFG_W         = 11;
    localparam int PIXEL_RESET   = 1024;

    localparam int SECTOR_SPAN   = 960;
    localparam int SECTOR_COUNT  = 8;
    localparam int ONE_SCALED    = 256 * SECTOR_SPAN;
    localparam int Q_SHIFT       = 22;
    localparam int Q_CLAMP       = 255 * 15;
    localparam int RECIP15       = 4370;

    localparam logic OP_RGB = 1'b0;
    localparam logic OP_HSV = 1'b1;

    // Each bit b goes out as 1,b,0, MSB first.
    function automatic logic [23:0] led_symbols(input logic [7:0] byte_in);
        logic [23:0] word;
        word = '0;
        for (int i = 0; i < 8; i++)
        begin
            word[3*i+2] = 1'b1;
            word[3*i+1] = byte_in[i];
            word[3*i]   = 1'b0;
        end
        return word;
    endfunction

endpackage

// ----- design/hsv_rgb_led_symbol_encoder_unit.sv -----
// Top level of the HSV/RGB LED symbol encoder: six-stage pipeline.
//
// Input request (s_tvalid/s_tready): s_tuser is op (0 = RGB bytes,
// 1 = HSV). s_tdata carries pixel index, RGB bytes and HSV fields.
// Output request (m_tvalid/m_tready): pixel address and the green, red and
// blue 24-bit SPI symbol words, each color bit b sent as 1,b,0, MSB first.
// cfg_wr_en/cfg_wr_data write pixel_count; write it only while idle.
// A request whose index is at or above pixel_count (or MAX_PIXELS) is taken
// and dropped; it gives no output.
// Each request passes the stage 0 to stage 5 registers in order; m_tvalid is
// the stage 5 valid. Throughput: one request per cycle while the output is not stalled; the
// path is set by the 17x18 multipliers in stage 3 and the reciprocal
// divide-by-15 in stage 4.
// Reset empties the pipeline and sets pixel_count to 1024.
// When m_tready is low, stages fill up behind the output one by one; any
// empty stage still takes new data, and s_tready drops only when all six
// stages hold a request. Nothing is lost or repeated.
`include "assert_macros.svh"

module hsv_rgb_led_symbol_encoder_unit
    import hsvled_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pixel_index[9:0], red[17:10], green[25:18], blue[33:26], hue[46:34],
    // saturation[55:47], brightness[64:56], zero pad[71:65]
    input  logic [S_DATA_W-1:0] s_tdata,
    // op
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // pixel_address[9:0], green_symbols[33:10], red_symbols[57:34],
    // blue_symbols[81:58], zero pad[87:82]
    output logic [M_DATA_W-1:0] m_tdata
);

    typedef struct packed {
        logic       op;
        logic [9:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] sector;
    } item_t;

    typedef struct packed {
        item_t       it;
        logic [9:0]  f;
        logic [8:0]  s;
        logic [16:0] k;
        logic [7:0]  v8;
    } s0_t;

    typedef struct packed {
        item_t       it;
        logic [18:0] fs;
        logic [18:0] gs;
        logic [8:0]  dp;
        logic [16:0] k;
        logic [7:0]  v8;
    } s1_t;

    typedef struct packed {
        item_t       it;
        logic [17:0] dq;
        logic [17:0] dt;
        logic [8:0]  dp;
        logic [16:0] k;
        logic [7:0]  v8;
    } s2_t;

    typedef struct packed {
        item_t       it;
        logic [34:0] qp;
        logic [34:0] tp;
        logic [25:0] pp;
        logic [7:0]  v8;
    } s3_t;

    typedef struct packed {
        item_t      it;
        logic [7:0] q8;
        logic [7:0] t8;
        logic [7:0] p8;
        logic [7:0] v8;
    } s4_t;

    typedef struct packed {
        logic [9:0]  idx;
        logic [23:0] gsym;
        logic [23:0] rsym;
        logic [23:0] bsym;
    } s5_t;

    logic [CFG_W-1:0] pixel_count_reg;
    logic [5:0]       vld_reg;
    logic [5:0]       vld_next;
    logic [5:0]       en;
    logic             in_range;

    s0_t s0_reg, s0_next;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;

    logic [9:0]  in_idx;
    logic [12:0] in_hue;
    logic [8:0]  in_sat;
    logic [8:0]  in_val;

    logic [12:0] xq;
    logic [12:0] xt;
    logic [25:0] qm;
    logic [25:0] tm;

    assign in_idx = s_tdata[9:0];
    assign in_hue = s_tdata[46:34];
    assign in_sat = s_tdata[55:47];
    assign in_val = s_tdata[64:56];

    assign in_range = (11'(in_idx) < pixel_count_reg) && (32'(in_idx) < MAX_PIXELS);

    // Per-stage advance: a stage moves when it is empty or its successor moves.
    always_comb
    begin
        en[5] = !vld_reg[5] || m_tready;
        for (int i = 4; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];

    always_comb
    begin
        vld_next[0] = s_tvalid && in_range;
        for (int i = 1; i < 6; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            pixel_count_reg <= CFG_W'(PIXEL_RESET);
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
            if (cfg_wr_en)
            begin
                pixel_count_reg <= cfg_wr_data;
            end
        end
    end

    // Stage 0: sector and fraction, 255*V.
    always_comb
    begin
        logic [3:0]  sec;
        logic [16:0] k;
        sec = '0;
        for (int j = 1; j <= SECTOR_COUNT; j++)
        begin
            if (in_hue >= 13'(j * SECTOR_SPAN))
            begin
                sec = 4'(j);
            end
        end
        k = 17'({in_val, 8'b0}) - 17'(in_val);
        s0_next.it.op     = s_tuser;
        s0_next.it.idx    = in_idx;
        s0_next.it.red    = s_tdata[17:10];
        s0_next.it.green  = s_tdata[25:18];
        s0_next.it.blue   = s_tdata[33:26];
        s0_next.it.sector = sec;
        s0_next.f  = 10'(in_hue - 13'(int'(sec) * SECTOR_SPAN));
        s0_next.s  = in_sat;
        s0_next.k  = k;
        s0_next.v8 = k[16] ? 8'hFF : k[15:8];
    end

    // Stage 1: f*S, (960-f)*S, 1-S.
    always_comb
    begin
        s1_next.it = s0_reg.it;
        s1_next.fs = 19'(s0_reg.f) * 19'(s0_reg.s);
        s1_next.gs = 19'(10'(SECTOR_SPAN) - s0_reg.f) * 19'(s0_reg.s);
        s1_next.dp = (s0_reg.s > 9'd256) ? 9'd0 : 9'(10'd256 - 10'(s0_reg.s));
        s1_next.k  = s0_reg.k;
        s1_next.v8 = s0_reg.v8;
    end

    // Stage 2: q and t factors, clamped at zero.
    always_comb
    begin
        s2_next.it = s1_reg.it;
        s2_next.dq = (s1_reg.fs >= 19'(ONE_SCALED)) ? 18'd0
                                                    : 18'(19'(ONE_SCALED) - s1_reg.fs);
        s2_next.dt = (s1_reg.gs >= 19'(ONE_SCALED)) ? 18'd0
                                                    : 18'(19'(ONE_SCALED) - s1_reg.gs);
        s2_next.dp = s1_reg.dp;
        s2_next.k  = s1_reg.k;
        s2_next.v8 = s1_reg.v8;
    end

    // Stage 3: scale by 255*V.
    always_comb
    begin
        s3_next.it = s2_reg.it;
        s3_next.qp = 35'(s2_reg.k) * 35'(s2_reg.dq);
        s3_next.tp = 35'(s2_reg.k) * 35'(s2_reg.dt);
        s3_next.pp = 26'(s2_reg.k) * 26'(s2_reg.dp);
        s3_next.v8 = s2_reg.v8;
    end

    // Stage 4: divide by 15*2^22 (q, t) and 2^16 (p), clamp to a byte.
    assign xq = s3_reg.qp[34:Q_SHIFT];
    assign xt = s3_reg.tp[34:Q_SHIFT];
    assign qm = 26'(xq) * 26'(RECIP15);
    assign tm = 26'(xt) * 26'(RECIP15);

    always_comb
    begin
        s4_next.it = s3_reg.it;
        s4_next.q8 = (xq >= 13'(Q_CLAMP)) ? 8'hFF : qm[23:16];
        s4_next.t8 = (xt >= 13'(Q_CLAMP)) ? 8'hFF : tm[23:16];
        s4_next.p8 = (s3_reg.pp[25:24] != 2'b00) ? 8'hFF : s3_reg.pp[23:16];
        s4_next.v8 = s3_reg.v8;
    end

    // Stage 5: channel select and symbol expansion.
    always_comb
    begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = s4_reg.it.red;
        g = s4_reg.it.green;
        b = s4_reg.it.blue;
        if (s4_reg.it.op == OP_HSV)
        begin
            case (s4_reg.it.sector)
                4'd0:
                begin
                    r = s4_reg.v8; g = s4_reg.t8; b = s4_reg.p8;
                end
                4'd1:
                begin
                    r = s4_reg.q8; g = s4_reg.v8; b = s4_reg.p8;
                end
                4'd2:
                begin
                    r = s4_reg.p8; g = s4_reg.v8; b = s4_reg.t8;
                end
                4'd3:
                begin
                    r = s4_reg.p8; g = s4_reg.q8; b = s4_reg.v8;
                end
                4'd4:
                begin
                    r = s4_reg.t8; g = s4_reg.p8; b = s4_reg.v8;
                end
                4'd5:
                begin
                    r = s4_reg.v8; g = s4_reg.p8; b = s4_reg.q8;
                end
                default:
                begin
                    r = 8'd0; g = 8'd0; b = 8'd0;
                end
            endcase
        end
        s5_next.idx  = s4_reg.it.idx;
        s5_next.gsym = led_symbols(g);
        s5_next.rsym = led_symbols(r);
        s5_next.bsym = led_symbols(b);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_reg <= s0_next;
        end
        if (en[1])
        begin
            s1_reg <= s1_next;
        end
        if (en[2])
        begin
            s2_reg <= s2_next;
        end
        if (en[3])
        begin
            s3_reg <= s3_next;
        end
        if (en[4])
        begin
            s4_reg <= s4_next;
        end
        if (en[5])
        begin
            s5_reg <= s5_next;
        end
    end

    assign m_tvalid = vld_reg[5];
    assign m_tdata  = {6'd0, s5_reg.bsym, s5_reg.rsym, s5_reg.gsym, s5_reg.idx};

    `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (vld_reg == 6'd0), "pipeline not empty in reset")
    `ASSERT_CLK(a_full_when_blocked, !s_tready |-> (vld_reg == 6'h3F),
        "input blocked with an empty stage")
    `ASSERT_CLK(a_drop_out_of_range, s_tready && !(s_tvalid && in_range) |=> !vld_reg[0],
        "dropped request entered the pipeline")
    `ASSERT_CLK(a_stall_holds, vld_reg[2] && !en[2] |=> vld_reg[2] && $stable(s2_reg),
        "stalled stage lost its request")
    `ASSERT_CLK(a_div15_exact,
        (xq < 13'(Q_CLAMP)) |-> (26'(qm[23:16]) * 26'd15 <= 26'(xq))
                               && (26'(xq) - 26'(qm[23:16]) * 26'd15 < 26'd15),
        "reciprocal divide by 15 off")

endmodule

// ----- sim/tb_hsv_rgb_led_symbol_encoder_unit.sv -----
// Self-checking testbench for the HSV/RGB LED symbol encoder: directed table, then random phases.
`timescale 1ns / 1ps

module tb_hsv_rgb_led_symbol_encoder_unit;
    import hsvled_pkg::*;

    localparam logic [23:0] SYM_ZERO = 24'h924924;
    localparam logic [23:0] SYM_FULL = 24'hDB6DB6;
    localparam int DRAIN_CYCLES      = 12;
    localparam int HOLD_CYCLES       = 300;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int NUM_PHASES        = 8;
    localparam int NUM_ROWS          = 28;

    typedef struct packed {
        logic        op;
        logic [9:0]  idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] hue;
        logic [8:0]  sat;
        logic [8:0]  val;
    } pixel_req_t;

    typedef struct packed {
        logic [9:0]  addr;
        logic [23:0] grn;
        logic [23:0] red;
        logic [23:0] blu;
    } led_word_t;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;
    typedef enum logic [1:0] { EXP_MODEL, EXP_NONE, EXP_FIXED } exp_kind_e;

    typedef struct {
        row_kind_e   kind;
        int          cfg;
        logic        op;
        int          idx;
        int          r;
        int          g;
        int          b;
        int          h;
        int          s;
        int          v;
        exp_kind_e   chk;
        logic [23:0] eg;
        logic [23:0] er;
        logic [23:0] eb;
    } dir_row_t;

    typedef struct {
        int cfg;
        int src_pct;
        int sink_pct;
        int items;
        bit hold;
        bit pause;
    } phase_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    led_word_t   pending_pixels[$];
    int unsigned chain_len = PIXEL_RESET;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int          hold_asked = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    dir_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_REQ, 0, OP_RGB, 0,     0,    0,    0,    0,    0,    0, EXP_FIXED,
          SYM_ZERO, SYM_ZERO, SYM_ZERO},
        '{ROW_REQ, 0, OP_RGB, 1023,  255,  255,  255,  0,    0,    0, EXP_FIXED,
          SYM_FULL, SYM_FULL, SYM_FULL},
        '{ROW_REQ, 0, OP_RGB, 'h155, 'ha5, 'h3c, 'h0f, 0,    0,    0, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_RGB, 'h2aa, 'h5a, 'hc3, 'hf0, 8191, 511,  511, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 2,     0,    0,    0,    0,    0,    256, EXP_FIXED,
          SYM_FULL, SYM_FULL, SYM_FULL},
        '{ROW_REQ, 0, OP_HSV, 3,     0,    0,    0,    2000, 256,  0, EXP_FIXED,
          SYM_ZERO, SYM_ZERO, SYM_ZERO},
        // hue past 360 degrees: black
        '{ROW_REQ, 0, OP_HSV, 4,     255,  255,  255,  6000, 256,  256, EXP_FIXED,
          SYM_ZERO, SYM_ZERO, SYM_ZERO},
        '{ROW_REQ, 0, OP_HSV, 5,     255,  255,  255,  8191, 511,  511, EXP_FIXED,
          SYM_ZERO, SYM_ZERO, SYM_ZERO},
        // saturation above 1.0 clamps p and t to 0
        '{ROW_REQ, 0, OP_HSV, 6,     0,    0,    0,    0,    511,  256, EXP_FIXED,
          SYM_ZERO, SYM_FULL, SYM_ZERO},
        // value above 1.0 clamps to 255
        '{ROW_REQ, 0, OP_HSV, 7,     0,    0,    0,    0,    0,    511, EXP_FIXED,
          SYM_FULL, SYM_FULL, SYM_FULL},
        '{ROW_REQ, 0, OP_HSV, 8,     0,    0,    0,    480,  256,  256, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 9,     0,    0,    0,    1440, 256,  256, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 10,    0,    0,    0,    2400, 256,  256, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 11,    0,    0,    0,    3360, 256,  256, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 12,    0,    0,    0,    4320, 256,  256, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 13,    0,    0,    0,    5280, 256,  256, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 14,    0,    0,    0,    959,  200,  180, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 15,    0,    0,    0,    960,  100,  256, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 16,    0,    0,    0,    5759, 256,  128, EXP_MODEL, 0, 0, 0},
        '{ROW_CFG, 1, OP_RGB, 0,     0,    0,    0,    0,    0,    0, EXP_NONE, 0, 0, 0},
        '{ROW_REQ, 0, OP_RGB, 0,     'h12, 'h34, 'h56, 0,    0,    0, EXP_MODEL, 0, 0, 0},
        '{ROW_REQ, 0, OP_RGB, 1,     255,  255,  255,  0,    0,    0, EXP_NONE, 0, 0, 0},
        '{ROW_REQ, 0, OP_HSV, 1023,  0,    0,    0,    100,  100,  100, EXP_NONE, 0, 0, 0},
        // empty chain blocks everything
        '{ROW_CFG, 0, OP_RGB, 0,     0,    0,    0,    0,    0,    0, EXP_NONE, 0, 0, 0},
        '{ROW_REQ, 0, OP_RGB, 0,     255,  255,  255,  0,    0,    0, EXP_NONE, 0, 0, 0},
        // count above MAX_PIXELS is capped
        '{ROW_CFG, 2047, OP_RGB, 0,  0,    0,    0,    0,    0,    0, EXP_NONE, 0, 0, 0},
        '{ROW_REQ, 0, OP_RGB, 1023,  0,    255,  0,    0,    0,    0, EXP_FIXED,
          SYM_FULL, SYM_ZERO, SYM_ZERO},
        '{ROW_CFG, 1024, OP_RGB, 0,  0,    0,    0,    0,    0,    0, EXP_NONE, 0, 0, 0}
    };

    // cfg -1: random count
    phase_t phases [NUM_PHASES] = '{
        '{1024, 0,  0,  265, 1'b0, 1'b0},
        '{2047, 48, 0,  265, 1'b0, 1'b0},
        '{1,    0,  48, 265, 1'b0, 1'b0},
        '{-1,   24, 24, 265, 1'b0, 1'b1},
        '{0,    48, 0,  60,  1'b0, 1'b0},
        '{1000, 0,  48, 265, 1'b0, 1'b0},
        '{-1,   24, 24, 265, 1'b0, 1'b0},
        '{1024, 0,  0,  265, 1'b1, 1'b0}
    };

    hsv_rgb_led_symbol_encoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [23:0] spi_symbols(input logic [7:0] c);
        logic [23:0] w;
        w = '0;
        for (int i = 7; i >= 0; i--)
        begin
            w = {w[20:0], 1'b1, c[i], 1'b0};
        end
        return w;
    endfunction

    function automatic logic [7:0] clip_byte(input longint x);
        if (x < 0)
            return 8'd0;
        if (x > 255)
            return 8'd255;
        return x[7:0];
    endfunction

    function automatic void hsv_to_bytes(input logic [12:0] hue, input logic [8:0] sat,
                                         input logic [8:0] val, output logic [7:0] r,
                                         output logic [7:0] g, output logic [7:0] b);
        longint h;
        longint s;
        longint v;
        longint f;
        longint pn;
        longint qn;
        longint tn;
        longint sector;
        logic [7:0] v8;
        logic [7:0] p8;
        logic [7:0] q8;
        logic [7:0] t8;
        h = longint'(hue);
        s = longint'(sat);
        v = longint'(val);
        sector = h / 960;
        f = h % 960;
        v8 = clip_byte((255 * v) / 256);
        pn = 255 * v * (256 - s);
        qn = 255 * v * (245760 - f * s);
        tn = 255 * v * (245760 - (960 - f) * s);
        p8 = clip_byte(pn < 0 ? -1 : pn / 65536);
        q8 = clip_byte(qn < 0 ? -1 : qn / 62914560);
        t8 = clip_byte(tn < 0 ? -1 : tn / 62914560);
        case (sector)
            0: {r, g, b} = {v8, t8, p8};
            1: {r, g, b} = {q8, v8, p8};
            2: {r, g, b} = {p8, v8, t8};
            3: {r, g, b} = {p8, q8, v8};
            4: {r, g, b} = {t8, p8, v8};
            5: {r, g, b} = {v8, p8, q8};
            default: {r, g, b} = 24'd0;
        endcase
    endfunction

    // Returns 0 when the pixel lies outside the chain.
    function automatic bit encode_pixel(input pixel_req_t q, output led_word_t w);
        int unsigned lim;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        lim = (chain_len > MAX_PIXELS) ? MAX_PIXELS : chain_len;
        w = '0;
        if (q.idx >= lim)
            return 1'b0;
        if (q.op == OP_RGB)
            {r, g, b} = {q.red, q.green, q.blue};
        else
            hsv_to_bytes(q.hue, q.sat, q.val, r, g, b);
        w.addr = q.idx;
        w.grn  = spi_symbols(g);
        w.red  = spi_symbols(r);
        w.blu  = spi_symbols(b);
        return 1'b1;
    endfunction

    function automatic pixel_req_t random_pixel();
        pixel_req_t q;
        int unsigned lim;
        lim = (chain_len > MAX_PIXELS) ? MAX_PIXELS : chain_len;
        q.op = 1'($urandom_range(1));
        if (lim > 0 && $urandom_range(99) < 85)
            q.idx = 10'($urandom_range(lim - 1));
        else
            q.idx = 10'($urandom_range(1023));
        q.red   = 8'($urandom_range(255));
        q.green = 8'($urandom_range(255));
        q.blue  = 8'($urandom_range(255));
        q.hue   = 13'(($urandom_range(99) < 90) ? $urandom_range(5759) : $urandom_range(8191));
        q.sat   = 9'(($urandom_range(99) < 85) ? $urandom_range(256) : $urandom_range(511));
        q.val   = 9'(($urandom_range(99) < 85) ? $urandom_range(256) : $urandom_range(511));
        return q;
    endfunction

    task automatic send_pixel(input pixel_req_t q);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.op;
        s_tdata  <= {7'd0, q.val, q.sat, q.hue, q.blue, q.green, q.red, q.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_pending();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_pixel_count(input int unsigned n);
        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        chain_len = 32'(n[CFG_W-1:0]);
    endtask

    // receiver: random stalls plus a long hold-off on demand
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asked)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        led_word_t got;
        led_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[9:0], m_tdata[33:10], m_tdata[57:34], m_tdata[81:58]};
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected request addr %0d g %h r %h b %h", $time,
                         got.addr, got.grn, got.red, got.blu);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected addr %0d g %h r %h b %h, actual addr %0d g %h r %h b %h",
                             $time, want.addr, want.grn, want.red, want.blu,
                             got.addr, got.grn, got.red, got.blu);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        pixel_req_t q;
        led_word_t w;
        dir_row_t row;
        int unsigned cnt;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                set_pixel_count(row.cfg);
            else
            begin
                q.op    = row.op;
                q.idx   = 10'(row.idx);
                q.red   = 8'(row.r);
                q.green = 8'(row.g);
                q.blue  = 8'(row.b);
                q.hue   = 13'(row.h);
                q.sat   = 9'(row.s);
                q.val   = 9'(row.v);
                send_pixel(q);
                if (row.chk == EXP_FIXED)
                    pending_pixels.push_back({q.idx, row.eg, row.er, row.eb});
                else if (row.chk == EXP_MODEL && encode_pixel(q, w))
                    pending_pixels.push_back(w);
            end
        end

        foreach (phases[p])
        begin
            cnt = (phases[p].cfg < 0) ? $urandom_range(1023, 2) : phases[p].cfg;
            set_pixel_count(cnt);
            src_idle_pct   = phases[p].src_pct;
            sink_stall_pct = phases[p].sink_pct;
            if (phases[p].hold)
                hold_asked++;
            for (int k = 0; k < phases[p].items; k++)
            begin
                if (phases[p].pause && k == phases[p].items / 2)
                    drain_pending();
                q = random_pixel();
                send_pixel(q);
                if (encode_pixel(q, w))
                    pending_pixels.push_back(w);
            end
        end

        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
